[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Simulation builds get the checks;
// synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check with the reset as a disable condition.
`define AST_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that must also hold while reset is asserted.
`define AST_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AST_RST(lbl, clk, rst_n, prop, msg)
`define AST_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/alas_pkg.sv]
package alas_pkg;

  localparam int COORD_BITS = 12;
  localparam int STEP_BITS  = COORD_BITS + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [STEP_BITS-1:0]  steps_t;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    CFG_DRAW_COLOR     = 2'd0,
    CFG_BASE_ALPHA     = 2'd1,
    CFG_INTENSITY_BITS = 2'd2
  } cfg_idx_t;

  typedef enum logic [5:0] {
    MODE_IDLE  = 6'b000001,
    MODE_HORIZ = 6'b000010,
    MODE_VERT  = 6'b000100,
    MODE_DIAG  = 6'b001000,
    MODE_YMAJ  = 6'b010000,
    MODE_XMAJ  = 6'b100000
  } line_mode_t;

  typedef enum logic [2:0] {
    ST_READY = 3'b001,
    ST_DIV   = 3'b010,
    ST_PAIR  = 3'b100
  } seq_state_t;

  typedef struct packed {
    logic   cmd;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_word_t;

  typedef struct packed {
    coord_t      pixel_x;
    coord_t      pixel_y;
    logic [31:0] pixel_value;
    logic        line_end;
  } out_word_t;

  // The weight and the base alpha only ever land in the top byte, so the
  // 32-bit wrap reduces to an 8-bit add there.
  function automatic out_word_t make_pixel(coord_t x, coord_t y, logic [7:0] w,
                                           logic last, logic [31:0] color,
                                           logic [7:0] alpha);
    out_word_t  p;
    logic [7:0] top;
    top           = color[31:24] + w + alpha;
    p.pixel_x     = x;
    p.pixel_y     = y;
    p.pixel_value = {top, color[23:0]};
    p.line_end    = last;
    return p;
  endfunction

endpackage

[rtl/alas_div.sv]
module alas_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  alas_pkg::coord_t       minor,
  input  alas_pkg::coord_t       major,
  output logic                   done,
  output logic [FRAC_BITS-1:0]   quot
);
  import alas_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  // Restoring division of (minor << FRAC_BITS) by major, one quotient bit a
  // cycle. The minor axis is shorter than the major one, so the remainder
  // starts below the divisor and the quotient fits in FRAC_BITS bits.
  coord_t                 rem_r, rem_nxt, major_r, major_nxt;
  logic [FRAC_BITS-1:0]   quot_r, quot_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   run_r, run_nxt, done_r, done_nxt;
  logic [COORD_BITS:0]    rem_sh, rem_sub;
  logic                   fits;

  always_comb begin
    rem_sh    = {rem_r, 1'b0};
    rem_sub   = rem_sh - {1'b0, major_r};
    fits      = rem_sh >= {1'b0, major_r};
    rem_nxt   = rem_r;
    major_nxt = major_r;
    quot_nxt  = quot_r;
    cnt_nxt   = cnt_r;
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    if (start) begin
      rem_nxt   = minor;
      major_nxt = major;
      quot_nxt  = '0;
      cnt_nxt   = CNT_W'(FRAC_BITS);
      run_nxt   = 1'b1;
    end else if (run_r) begin
      rem_nxt  = fits ? rem_sub[COORD_BITS-1:0] : rem_sh[COORD_BITS-1:0];
      quot_nxt = {quot_r[FRAC_BITS-2:0], fits};
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r   <= rem_nxt;
    major_r <= major_nxt;
    quot_r  <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

[rtl/antialiased_line_stepper.sv]
// Wu antialiased line stepper. A start word (cmd 0) latches two endpoints,
// orders them so that y grows and returns the near endpoint at once. Each
// advance word (cmd 1) returns the next pixel, or a weighted pair of pixels
// for lines that are neither axis-aligned nor at 45 degrees; the last pixel
// carries line_end. A sloped line's start word also starts a shared restoring
// divider producing one quotient bit a cycle, and no new word is taken until
// the slope is in. A new word is taken only once the output register has
// drained, and the second word of a pair is offered once the first is taken.
// An advance while no line is active returns nothing. Configuration writes
// are always taken.
module antialiased_line_stepper #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  alas_pkg::in_word_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output alas_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import alas_pkg::*;

  localparam int SH_W = $clog2(FRAC_BITS + 1);

  // Configuration.
  logic [31:0] color_r, color_nxt;
  logic [7:0]  alpha_r, alpha_nxt;
  logic [3:0]  ibits_r, ibits_nxt;

  // Line state.
  seq_state_t           state_r, state_nxt;
  line_mode_t           mode_r, mode_nxt;
  coord_t               cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  coord_t               far_x_r, far_x_nxt, far_y_r, far_y_nxt;
  logic                 xneg_r, xneg_nxt;
  steps_t               steps_r, steps_nxt;
  logic [FRAC_BITS-1:0] acc_r, acc_nxt, estep_r, estep_nxt;

  // Output register and the held second word of a pair.
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt, pend_r, pend_nxt;

  logic in_fire, out_fire;

  // Start decode.
  logic       swap, s_xneg, single, div_start, div_done;
  coord_t     x0, y0, x1, y1, dx, dy, div_minor, div_major;
  line_mode_t s_mode;
  steps_t     s_steps;
  logic [FRAC_BITS-1:0] div_quot;

  // Advance datapath.
  coord_t               x_nx, y_nx, px, py, px2, py2;
  logic [FRAC_BITS-1:0] nw, w_full;
  logic                 minor_step;
  logic [3:0]           eff;
  logic [SH_W-1:0]      shamt;
  logic [8:0]           levels;
  logic [7:0]           w, cmask;
  steps_t               steps_dec;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign in_stall = !((state_r == ST_READY) && !out_valid_r);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  always_comb begin
    swap = in_data.start_y > in_data.end_y;
    x0   = swap ? in_data.end_x   : in_data.start_x;
    y0   = swap ? in_data.end_y   : in_data.start_y;
    x1   = swap ? in_data.start_x : in_data.end_x;
    y1   = swap ? in_data.start_y : in_data.end_y;
    s_xneg = x1 < x0;
    dx   = s_xneg ? x0 - x1 : x1 - x0;
    dy   = y1 - y0;
    div_minor = dx;
    div_major = dy;
    if (dy == '0) begin
      s_mode  = MODE_HORIZ;
      s_steps = {1'b0, dx};
    end else if (dx == '0) begin
      s_mode  = MODE_VERT;
      s_steps = {1'b0, dy};
    end else if (dx == dy) begin
      s_mode  = MODE_DIAG;
      s_steps = {1'b0, dy};
    end else if (dx < dy) begin
      s_mode  = MODE_YMAJ;
      s_steps = {1'b0, dy} - STEP_BITS'(1);
    end else begin
      s_mode    = MODE_XMAJ;
      s_steps   = {1'b0, dx} - STEP_BITS'(1);
      div_minor = dy;
      div_major = dx;
    end
    single = (dx == '0) && (dy == '0);
  end

  always_comb begin
    x_nx       = xneg_r ? cur_x_r - COORD_BITS'(1) : cur_x_r + COORD_BITS'(1);
    y_nx       = cur_y_r + COORD_BITS'(1);
    nw         = acc_r + estep_r;
    minor_step = nw <= acc_r;
    if (mode_r == MODE_YMAJ) begin
      px  = minor_step ? x_nx : cur_x_r;
      py  = y_nx;
      px2 = xneg_r ? px - COORD_BITS'(1) : px + COORD_BITS'(1);
      py2 = py;
    end else begin
      px  = x_nx;
      py  = minor_step ? y_nx : cur_y_r;
      px2 = px;
      py2 = py + COORD_BITS'(1);
    end
    if (ibits_r == 4'd0) begin
      eff = 4'd1;
    end else if (ibits_r > 4'd8) begin
      eff = 4'd8;
    end else begin
      eff = ibits_r;
    end
    shamt     = SH_W'(FRAC_BITS) - SH_W'(eff);
    w_full    = nw >> shamt;
    w         = w_full[7:0];
    levels    = 9'd1 << eff;
    cmask     = 8'(levels - 9'd1);
    steps_dec = steps_r - STEP_BITS'(1);
  end

  always_comb begin
    color_nxt     = color_r;
    alpha_nxt     = alpha_r;
    ibits_nxt     = ibits_r;
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    far_x_nxt     = far_x_r;
    far_y_nxt     = far_y_r;
    xneg_nxt      = xneg_r;
    steps_nxt     = steps_r;
    acc_nxt       = acc_r;
    estep_nxt     = estep_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    pend_nxt      = pend_r;
    div_start     = 1'b0;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_DRAW_COLOR:     color_nxt = cfg_data;
        CFG_BASE_ALPHA:     alpha_nxt = cfg_data[7:0];
        CFG_INTENSITY_BITS: ibits_nxt = cfg_data[3:0];
        default: ;
      endcase
    end

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_READY: begin
        if (in_fire && in_data.cmd == CMD_START) begin
          cur_x_nxt     = x0;
          cur_y_nxt     = y0;
          far_x_nxt     = x1;
          far_y_nxt     = y1;
          xneg_nxt      = s_xneg;
          steps_nxt     = s_steps;
          acc_nxt       = '0;
          estep_nxt     = '0;
          mode_nxt      = single ? MODE_IDLE : s_mode;
          out_word_nxt  = make_pixel(x0, y0, 8'd0, single, color_r, alpha_r);
          out_valid_nxt = 1'b1;
          if (s_mode == MODE_YMAJ || s_mode == MODE_XMAJ) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end else if (in_fire) begin
          case (mode_r)
            MODE_HORIZ, MODE_VERT, MODE_DIAG: begin
              if (mode_r != MODE_VERT) cur_x_nxt = x_nx;
              if (mode_r != MODE_HORIZ) cur_y_nxt = y_nx;
              steps_nxt = steps_dec;
              if (steps_dec == '0) mode_nxt = MODE_IDLE;
              out_word_nxt = make_pixel((mode_r != MODE_VERT) ? x_nx : cur_x_r,
                                        (mode_r != MODE_HORIZ) ? y_nx : cur_y_r,
                                        8'd0, steps_dec == '0, color_r, alpha_r);
              out_valid_nxt = 1'b1;
            end
            MODE_YMAJ, MODE_XMAJ: begin
              if (steps_r == '0) begin
                mode_nxt     = MODE_IDLE;
                out_word_nxt = make_pixel(far_x_r, far_y_r, 8'd0, 1'b1,
                                          color_r, alpha_r);
                out_valid_nxt = 1'b1;
              end else begin
                acc_nxt       = nw;
                cur_x_nxt     = px;
                cur_y_nxt     = py;
                steps_nxt     = steps_dec;
                out_word_nxt  = make_pixel(px, py, w, 1'b0, color_r, alpha_r);
                pend_nxt      = make_pixel(px2, py2, w ^ cmask, 1'b0,
                                           color_r, alpha_r);
                out_valid_nxt = 1'b1;
                state_nxt     = ST_PAIR;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          estep_nxt = div_quot;
          state_nxt = ST_READY;
        end
      end
      ST_PAIR: begin
        if (out_fire) begin
          out_word_nxt  = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_READY;
        end
      end
      default: state_nxt = ST_READY;
    endcase
  end

  alas_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .minor (div_minor),
    .major (div_major),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r     <= 32'h00FF_FFFF;
      alpha_r     <= '0;
      ibits_r     <= 4'd8;
      state_r     <= ST_READY;
      mode_r      <= MODE_IDLE;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      far_x_r     <= '0;
      far_y_r     <= '0;
      xneg_r      <= 1'b0;
      steps_r     <= '0;
      acc_r       <= '0;
      estep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      color_r     <= color_nxt;
      alpha_r     <= alpha_nxt;
      ibits_r     <= ibits_nxt;
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      far_x_r     <= far_x_nxt;
      far_y_r     <= far_y_nxt;
      xneg_r      <= xneg_nxt;
      steps_r     <= steps_nxt;
      acc_r       <= acc_nxt;
      estep_r     <= estep_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_word_r <= out_word_nxt;
    pend_r     <= pend_nxt;
  end

`include "assert_macros.svh"

  // While the second word of a pair waits, the first must still be on offer.
  `AST_RST(a_pair_has_word, clk, rst_n, (state_r == ST_PAIR) |-> out_valid_r, "pair state without an output word")
  // A finished division always hands control back to the ready state.
  `AST_RST(a_div_returns, clk, rst_n, (state_r == ST_DIV && div_done) |=> (state_r == ST_READY), "divider result not taken")
  // No line active means no steps left to walk.
  `AST_RST(a_idle_no_steps, clk, rst_n, (mode_r == MODE_IDLE) |-> (steps_r == '0), "idle with steps remaining")
  // The divider is only ever busy while the sequencer waits for it.
  `AST_RST(a_div_only_in_div, clk, rst_n, div_done |-> (state_r == ST_DIV), "divider finished outside the divide state")

endmodule

[bench/tb_antialiased_line_stepper.sv]
module tb_antialiased_line_stepper;
  timeunit 1ns;
  timeprecision 1ps;

  import alas_pkg::*;

  localparam int FRAC         = 16;
  localparam int PERIOD       = 20;
  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
  localparam int PHASES       = 6;
  localparam int PHASE_WORDS  = 105;
  localparam int DRAIN_CYCLES = 2 * (FRAC + 3);
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam logic [31:0] RESET_COLOR = 32'h00FF_FFFF;
  localparam logic [1:0]  CFG_UNUSED  = 2'd3;

  typedef struct {
    coord_t          cx;
    coord_t          cy;
    coord_t          fx;
    coord_t          fy;
    logic            xneg;
    steps_t          left;
    logic [FRAC-1:0] acc;
    logic [FRAC-1:0] stp;
    line_mode_t      mode;
  } walker_t;

  typedef struct {
    in_word_t  word;
    bit        fixed;
    out_word_t pixel;
  } stim_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  // Line walker state and the register copy that it colours pixels with.
  walker_t     walk;
  logic [31:0] color_reg;
  logic [7:0]  alpha_reg;
  logic [3:0]  ibits_reg;

  out_word_t pixel_q[$];
  stim_row_t stim_rows[$];

  bit quiet;
  bit hold_request;
  int holds_done;
  int words_taken;
  int idle_advances;
  int lines_started;
  int reg_writes;
  int pixels_seen;
  int mismatches;
  int idle_cycles;

  antialiased_line_stepper #(.FRAC_BITS(FRAC)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(PERIOD / 2) clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic coord_t rand_coord();
    return coord_t'($urandom_range(0, COORD_MAX));
  endfunction

  // Moves a coordinate by d in a random direction, staying inside the grid.
  function automatic coord_t nudge(coord_t base, int d);
    if (int'(base) + d > COORD_MAX || (int'(base) >= d && $urandom_range(0, 1) == 1))
      return coord_t'(int'(base) - d);
    return coord_t'(int'(base) + d);
  endfunction

  function automatic out_word_t shade(coord_t x, coord_t y, logic [7:0] w, logic last);
    out_word_t p;
    p.pixel_x     = x;
    p.pixel_y     = y;
    p.pixel_value = color_reg + {w, 24'd0} + {alpha_reg, 24'd0};
    p.line_end    = last;
    return p;
  endfunction

  function automatic coord_t step_x(coord_t x);
    return walk.xneg ? coord_t'(x - 1'b1) : coord_t'(x + 1'b1);
  endfunction

  // Returns the number of pixels a word produces and advances the walker.
  function automatic int rasterize_word(in_word_t w, output out_word_t px [2]);
    coord_t          x0, y0, x1, y1, t, dx, dy;
    logic [31:0]     q;
    logic [3:0]      b;
    logic [7:0]      lvl_mask, wt;
    logic [FRAC-1:0] old, nw;
    px[0] = '0;
    px[1] = '0;
    if (w.cmd == CMD_START) begin
      x0 = w.start_x;
      y0 = w.start_y;
      x1 = w.end_x;
      y1 = w.end_y;
      if (y0 > y1) begin
        t = y0; y0 = y1; y1 = t;
        t = x0; x0 = x1; x1 = t;
      end
      walk.cx   = x0;
      walk.cy   = y0;
      walk.fx   = x1;
      walk.fy   = y1;
      walk.xneg = (x1 < x0);
      dx        = walk.xneg ? coord_t'(x0 - x1) : coord_t'(x1 - x0);
      dy        = coord_t'(y1 - y0);
      walk.acc  = '0;
      walk.stp  = '0;
      if (dy == 0) begin
        walk.mode = MODE_HORIZ;
        walk.left = steps_t'(dx);
      end else if (dx == 0) begin
        walk.mode = MODE_VERT;
        walk.left = steps_t'(dy);
      end else if (dx == dy) begin
        walk.mode = MODE_DIAG;
        walk.left = steps_t'(dy);
      end else if (dx < dy) begin
        walk.mode = MODE_YMAJ;
        walk.left = steps_t'(dy) - 1'b1;
        q         = (32'(dx) << FRAC) / 32'(dy);
        walk.stp  = q[FRAC-1:0];
      end else begin
        walk.mode = MODE_XMAJ;
        walk.left = steps_t'(dx) - 1'b1;
        q         = (32'(dy) << FRAC) / 32'(dx);
        walk.stp  = q[FRAC-1:0];
      end
      if (walk.mode inside {MODE_HORIZ, MODE_VERT, MODE_DIAG} && walk.left == 0) begin
        walk.mode = MODE_IDLE;
        px[0] = shade(x0, y0, 8'd0, 1'b1);
      end else begin
        px[0] = shade(x0, y0, 8'd0, 1'b0);
      end
      return 1;
    end
    case (walk.mode)
      MODE_HORIZ, MODE_VERT, MODE_DIAG: begin
        if (walk.mode != MODE_VERT) walk.cx = step_x(walk.cx);
        if (walk.mode != MODE_HORIZ) walk.cy = walk.cy + 1'b1;
        walk.left = walk.left - 1'b1;
        if (walk.left == 0) walk.mode = MODE_IDLE;
        px[0] = shade(walk.cx, walk.cy, 8'd0, walk.left == 0);
        return 1;
      end
      MODE_YMAJ, MODE_XMAJ: begin
        if (walk.left == 0) begin
          walk.mode = MODE_IDLE;
          px[0] = shade(walk.fx, walk.fy, 8'd0, 1'b1);
          return 1;
        end
        b = ibits_reg;
        if (b < 4'd1) b = 4'd1;
        if (b > 4'd8) b = 4'd8;
        lvl_mask = 8'((16'd1 << b) - 16'd1);
        old      = walk.acc;
        nw       = old + walk.stp;
        walk.acc = nw;
        // The minor axis steps when the accumulator wraps past zero.
        if (walk.mode == MODE_YMAJ) begin
          if (nw <= old) walk.cx = step_x(walk.cx);
          walk.cy = walk.cy + 1'b1;
        end else begin
          if (nw <= old) walk.cy = walk.cy + 1'b1;
          walk.cx = step_x(walk.cx);
        end
        wt    = 8'(nw >> (FRAC - int'(b)));
        px[0] = shade(walk.cx, walk.cy, wt, 1'b0);
        if (walk.mode == MODE_YMAJ)
          px[1] = shade(step_x(walk.cx), walk.cy, wt ^ lvl_mask, 1'b0);
        else
          px[1] = shade(walk.cx, coord_t'(walk.cy + 1'b1), wt ^ lvl_mask, 1'b0);
        walk.left = walk.left - 1'b1;
        return 2;
      end
      default: return 0;
    endcase
  endfunction

  task automatic send_word(input in_word_t w, input bit fixed, input out_word_t fixed_px);
    int        gap;
    int        n;
    out_word_t px [2];
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    words_taken++;
    if (w.cmd == CMD_START) lines_started++;
    else if (walk.mode == MODE_IDLE) idle_advances++;
    n = rasterize_word(w, px);
    if (fixed) begin
      pixel_q.push_back(fixed_px);
    end else begin
      for (int i = 0; i < n; i++) pixel_q.push_back(px[i]);
    end
  endtask

  task automatic send_advance();
    in_word_t w;
    w.cmd     = CMD_ADVANCE;
    w.start_x = rand_coord();
    w.start_y = rand_coord();
    w.end_x   = rand_coord();
    w.end_y   = rand_coord();
    send_word(w, 1'b0, '0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    case (idx)
      CFG_DRAW_COLOR:     color_reg = value;
      CFG_BASE_ALPHA:     alpha_reg = value[7:0];
      CFG_INTENSITY_BITS: ibits_reg = value[3:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every pixel has come back, then give an idle advance time to retire.
  task automatic settle();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic draw_random_line();
    int       kind, d, minor, adv_cap, k;
    coord_t   x0, y0, x1, y1, t;
    in_word_t w;
    kind    = $urandom_range(0, 99);
    d       = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(2, 12);
    adv_cap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : 1 << 20;
    x0      = rand_coord();
    y0      = rand_coord();
    x1      = x0;
    y1      = y0;
    if (kind < 6) begin
      send_advance();
      return;
    end else if (kind < 12) begin
      // single point: nothing to change
    end else if (kind < 24) begin
      x1 = nudge(x0, d);
    end else if (kind < 36) begin
      y1 = nudge(y0, d);
    end else if (kind < 48) begin
      x1 = nudge(x0, d);
      y1 = nudge(y0, d);
    end else if (kind < 92) begin
      minor = $urandom_range(1, d - 1);
      if ($urandom_range(0, 1) == 1) begin
        x1 = nudge(x0, minor);
        y1 = nudge(y0, d);
      end else begin
        x1 = nudge(x0, d);
        y1 = nudge(y0, minor);
      end
    end else begin
      // Line between two random grid points, left after at most eight advances.
      x1      = rand_coord();
      y1      = rand_coord();
      adv_cap = $urandom_range(0, 8);
    end
    if ($urandom_range(0, 1) == 1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    w.cmd     = CMD_START;
    w.start_x = x0;
    w.start_y = y0;
    w.end_x   = x1;
    w.end_y   = y1;
    send_word(w, 1'b0, '0);
    k = 0;
    while (walk.mode != MODE_IDLE && k < adv_cap) begin
      send_advance();
      k++;
    end
  endtask

  function automatic stim_row_t stim_row(logic cmd, int sx, int sy, int ex, int ey,
                                         bit fixed, int px, int py, logic last);
    stim_row_t r;
    r.word  = '{cmd, coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey)};
    r.fixed = fixed;
    r.pixel = '{coord_t'(px), coord_t'(py), RESET_COLOR, last};
    return r;
  endfunction

  function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("pixel %0d: %s expected 0x%0h, got 0x%0h", pixels_seen, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      pixels_seen++;
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel %0d: unexpected word x=%0d y=%0d value=0x%0h end=%0b", pixels_seen,
                   out_data.pixel_x, out_data.pixel_y, out_data.pixel_value, out_data.line_end);
      end else begin
        want = pixel_q.pop_front();
        report_field("pixel_x", 32'(want.pixel_x), 32'(out_data.pixel_x));
        report_field("pixel_y", 32'(want.pixel_y), 32'(out_data.pixel_y));
        report_field("pixel_value", want.pixel_value, out_data.pixel_value);
        report_field("line_end", 32'(want.line_end), 32'(out_data.line_end));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("no word moved for %0d cycles, %0d pixels outstanding",
                 STALL_LIMIT, pixel_q.size());
        $display("[antialiased_line_stepper] ERROR");
        $finish;
      end
    end
  end

  // Output side: runs of readiness broken by lulls, plus one long hold-off on request.
  initial begin : receiver
    int run_len, lull;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        holds_done++;
      end
      out_stall <= 1'b0;
      run_len = $urandom_range(1, 30);
      repeat (run_len) @(posedge clk);
      lull = pick_gap();
      if (lull > 0) begin
        out_stall <= 1'b1;
        repeat (lull) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int          phase_end;
    bit          hold_issued;
    logic [31:0] colour, alpha_word, ibits_word;
    walk.cx   = '0;
    walk.cy   = '0;
    walk.fx   = '0;
    walk.fy   = '0;
    walk.xneg = 1'b0;
    walk.left = '0;
    walk.acc  = '0;
    walk.stp  = '0;
    walk.mode = MODE_IDLE;
    color_reg = RESET_COLOR;
    alpha_reg = 8'd0;
    ibits_reg = 4'd8;
    hold_issued = 1'b0;

    // Register values after reset; fixed rows carry the pixel that must come back.
    stim_rows.push_back(stim_row(CMD_START, 0, 0, 0, 0, 1, 0, 0, 1));
    stim_rows.push_back(stim_row(CMD_START, 4095, 4095, 4095, 4095, 1, 4095, 4095, 1));
    stim_rows.push_back(stim_row(CMD_ADVANCE, 4095, 4095, 4095, 4095, 0, 0, 0, 0));
    stim_rows.push_back(stim_row(CMD_START, 4093, 7, 4095, 7, 1, 4093, 7, 0));
    stim_rows.push_back(stim_row(CMD_ADVANCE, 0, 0, 0, 0, 1, 4094, 7, 0));
    stim_rows.push_back(stim_row(CMD_ADVANCE, 0, 0, 0, 0, 1, 4095, 7, 1));
    stim_rows.push_back(stim_row(CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0));
    stim_rows.push_back(stim_row(CMD_START, 5, 4095, 5, 4093, 1, 5, 4093, 0));
    stim_rows.push_back(stim_row(CMD_ADVANCE, 0, 0, 0, 0, 1, 5, 4094, 0));
    stim_rows.push_back(stim_row(CMD_ADVANCE, 0, 0, 0, 0, 1, 5, 4095, 1));
    stim_rows.push_back(stim_row(CMD_START, 10, 0, 8, 2, 1, 10, 0, 0));
    stim_rows.push_back(stim_row(CMD_ADVANCE, 0, 0, 0, 0, 1, 9, 1, 0));
    stim_rows.push_back(stim_row(CMD_ADVANCE, 0, 0, 0, 0, 1, 8, 2, 1));
    stim_rows.push_back(stim_row(CMD_START, 0, 0, 1, 4095, 1, 0, 0, 0));
    stim_rows.push_back(stim_row(CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0));
    stim_rows.push_back(stim_row(CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0));
    // A new start abandons the steep line above.
    stim_rows.push_back(stim_row(CMD_START, 4095, 0, 0, 1, 1, 4095, 0, 0));
    stim_rows.push_back(stim_row(CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0));
    stim_rows.push_back(stim_row(CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0));
    stim_rows.push_back(stim_row(CMD_START, 2, 3, 5, 4, 1, 2, 3, 0));
    stim_rows.push_back(stim_row(CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0));
    stim_rows.push_back(stim_row(CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0));
    stim_rows.push_back(stim_row(CMD_ADVANCE, 0, 0, 0, 0, 1, 5, 4, 1));
    stim_rows.push_back(stim_row(CMD_START, 3, 5, 2, 2, 1, 2, 2, 0));
    stim_rows.push_back(stim_row(CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) send_word(stim_rows[i].word, stim_rows[i].fixed, stim_rows[i].pixel);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      colour     = $urandom();
      alpha_word = $urandom();
      ibits_word = $urandom();
      case (ph)
        0: begin
          colour     = 32'hFFFF_FFFF;
          alpha_word = 32'hFF;
          ibits_word = 32'd1;
        end
        1: begin
          colour     = 32'd0;
          alpha_word = 32'd0;
          ibits_word = 32'd8;
        end
        2: ibits_word[3:0] = 4'd0;
        3: ibits_word[3:0] = 4'd15;
        5: ibits_word[3:0] = 4'($urandom_range(2, 7));
        default: ;
      endcase
      write_reg(CFG_DRAW_COLOR, colour);
      write_reg(CFG_BASE_ALPHA, alpha_word);
      write_reg(CFG_INTENSITY_BITS, ibits_word);
      if (ph == 3) write_reg(CFG_UNUSED, $urandom());
      quiet     = (ph == 4);
      phase_end = words_taken - idle_advances + PHASE_WORDS;
      while (words_taken - idle_advances < phase_end) begin
        if (ph == 2 && !hold_issued && words_taken - idle_advances >= phase_end - 70) begin
          hold_request = 1'b1;
          hold_issued  = 1'b1;
        end
        draw_random_line();
      end
    end

    settle();
    $display("%0d words taken (%0d advances with no line active), %0d lines started",
             words_taken, idle_advances, lines_started);
    $display("%0d pixels checked over %0d register writes, %0d long output hold-off(s)",
             pixels_seen, reg_writes, holds_done);
    if (mismatches == 0) begin
      $display("[antialiased_line_stepper] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[antialiased_line_stepper] ERROR");
    end
    $finish;
  end

endmodule
